FILE: design/lbsa_pkg.sv
// ----------------------------------------------------------------------------
// lbsa_pkg
// Shared types, codes and sizes of the log batch space allocator.
// ----------------------------------------------------------------------------
package lbsa_pkg;

  // Queue and batch sizes
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned MAX_ABSORB      = 16;
  localparam int unsigned NW              = $clog2(MAX_ABSORB + 1);

  // Divider width: covers tail plus record sectors
  localparam int unsigned DW = 33;

  // Operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_FORM = 2'd1;
  localparam logic [1:0] OP_HEAD = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_QFULL   = 3'd1;
  localparam logic [2:0] ST_BATCHED = 3'd2;
  localparam logic [2:0] ST_LOGFULL = 3'd3;
  localparam logic [2:0] ST_QEMPTY  = 3'd4;
  localparam logic [2:0] ST_HEADSET = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_LOG_SECTORS = 3'd0;
  localparam logic [2:0] CFG_SECTOR_BYTES = 3'd1;
  localparam logic [2:0] CFG_BLOCK_BYTES = 3'd2;
  localparam logic [2:0] CFG_RESERVE = 3'd3;
  localparam logic [2:0] CFG_HEADER = 3'd4;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_ITEM,
    DIV_TOTAL,
    DIV_MOD
  } div_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       cap;
    logic       enq;
    logic       set_head;
    logic       walk_init;
    logic       take;
    logic       skip;
    logic       div_go;
    div_sel_e   div_sel;
    logic       place;
    logic       commit;
    logic       swp_init;
    logic       swp_copy;
    logic       swp_done;
    logic       emit;
    logic [2:0] st;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       q_full;
    logic       q_empty;
    logic       walk_end;
    logic       over_blk;
    logic       fits;
    logic       n_zero;
    logic       div_done;
    logic       out_free;
    logic       swp_end;
    logic       swp_taken;
  } sts_t;

endpackage

FILE: design/lbsa_div.sv
// ----------------------------------------------------------------------------
// lbsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbsa_div
  import lbsa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [31:0]   rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] qd_q;
  logic [31:0]   rem_q;
  logic [31:0]   dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [32:0] sh;
  logic [33:0] diff;
  logic        qbit;

  // Trial subtract of the shifted remainder
  assign sh   = {rem_q, qd_q[DW-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs_q};
  assign qbit = ~diff[33];

  // Step the quotient and remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qd_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      qd_q  <= {qd_q[DW-2:0], qbit};
      rem_q <= qbit ? diff[31:0] : sh[31:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = qd_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/lbsa_dp.sv
// ----------------------------------------------------------------------------
// lbsa_dp
// Datapath: configuration, pending queue, log pointers, batch walk and
// the output register.
// ----------------------------------------------------------------------------
module lbsa_dp
  import lbsa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  item_tag_i,
  input  logic [20:0] item_bytes_i,
  input  logic        item_frees_i,
  input  logic [31:0] new_head_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  status_o,
  output logic [7:0]  out_tag_o,
  output logic [31:0] batch_offset_o,
  output logic [31:0] batch_end_o,
  output logic        batch_wraps_o,
  output logic [31:0] wrap_offset_o,
  output logic [11:0] batch_sectors_o,
  output logic [63:0] seq_low_o,
  output logic [63:0] seq_high_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Configuration registers
  logic [31:0] log_sectors_q;
  logic [16:0] sector_bytes_q;
  logic [20:0] block_bytes_q;
  logic [31:0] reserve_q;
  logic [12:0] header_q;

  // Captured request
  logic [1:0]  op_q;
  logic [7:0]  tag_q;
  logic [20:0] ibytes_q;
  logic        ifrees_q;
  logic [31:0] nhead_q;

  // Pending queue
  logic [20:0] mem_bytes_q [QUEUE_DEPTH];
  logic        mem_frees_q [QUEUE_DEPTH];
  logic [7:0]  mem_tags_q  [QUEUE_DEPTH];
  logic [IW-1:0] count_q;

  // Log pointers
  logic [31:0] tail_q;
  logic [31:0] head_q;
  logic [63:0] seq_q;

  // Walk and sweep state
  logic [IW-1:0]          idx_q;
  logic [IW-1:0]          wr_q;
  logic [NW-1:0]          n_q;
  logic [NW-1:0]          k_q;
  logic [21:0]            bytes_q;
  logic                   all_free_q;
  logic [31:0]            room_q;
  logic [31:0]            base_q;
  logic [QUEUE_DEPTH-1:0] taken_q;
  logic [23:0]            nsec_q;
  logic                   wraps_q;
  logic [31:0]            off_q;
  logic [31:0]            wrapoff_q;
  logic [63:0]            seqlo_q;
  logic [63:0]            seqhi_q;

  // Output register
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [7:0]  otag_q;
  logic [31:0] obatch_off_q;
  logic [31:0] oend_q;
  logic        owraps_q;
  logic [31:0] owrapoff_q;
  logic [11:0] osec_q;
  logic [63:0] oseqlo_q;
  logic [63:0] oseqhi_q;
  logic        olast_q;

  // Divider link
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [31:0]   div_rem;
  logic [DW-1:0] div_dvd;
  logic [31:0]   div_dvs;

  logic [AW-1:0] ridx;
  logic [20:0]   rd_bytes;
  logic          rd_frees;
  logic [7:0]    rd_tag;
  logic [16:0]   sb_eff;
  logic [22:0]   sum;
  logic [23:0]   item_dvd;
  logic [23:0]   tot_dvd;
  logic [32:0]   mod_dvd;
  logic [33:0]   consume;
  logic [31:0]   avail;
  logic [31:0]   used;
  logic [31:0]   free_sec;
  logic [31:0]   room;
  logic [31:0]   end_off;
  logic          out_free;

  assign ridx     = idx_q[AW-1:0];
  assign rd_bytes = mem_bytes_q[ridx];
  assign rd_frees = mem_frees_q[ridx];
  assign rd_tag   = mem_tags_q[ridx];
  assign sb_eff   = (sector_bytes_q == '0) ? 17'd1 : sector_bytes_q;
  assign out_free = ~out_valid_q | out_ready_i;

  // Byte totals and ceiling dividends
  assign sum      = {1'b0, bytes_q} + {2'b00, rd_bytes};
  assign item_dvd = {1'b0, sum} + {7'd0, sb_eff} - 24'd1;
  assign tot_dvd  = {2'b00, bytes_q} + {7'd0, sb_eff} - 24'd1;
  assign mod_dvd  = wraps_q ? {9'd0, nsec_q} : ({1'b0, tail_q} + {9'd0, nsec_q});

  // Select divider operands
  always_comb begin
    div_dvd = {9'd0, item_dvd};
    div_dvs = {15'd0, sb_eff};
    case (cmd_i.div_sel)
      DIV_TOTAL: div_dvd = {9'd0, tot_dvd};
      DIV_MOD: begin
        div_dvd = mod_dvd;
        div_dvs = log_sectors_q;
      end
      default: div_dvd = {9'd0, item_dvd};
    endcase
  end

  lbsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Free sectors between tail and head, and room to region end
  always_comb begin
    if (tail_q >= head_q) begin
      used = tail_q - head_q;
    end else if ((head_q - tail_q) > log_sectors_q) begin
      used = log_sectors_q;
    end else begin
      used = log_sectors_q - (head_q - tail_q);
    end
    if (({1'b0, used} + 33'd1) >= {1'b0, log_sectors_q}) begin
      free_sec = '0;
    end else begin
      free_sec = log_sectors_q - used - 32'd1;
    end
    room = (tail_q >= log_sectors_q) ? 32'd0 : log_sectors_q - tail_q;
  end

  // Fit test of the current item
  always_comb begin
    if (div_quot <= {1'b0, room_q}) begin
      consume = {1'b0, div_quot};
    end else begin
      consume = {2'b00, room_q} + {1'b0, div_quot};
    end
    if (all_free_q && rd_frees) begin
      avail = base_q;
    end else begin
      avail = (base_q > reserve_q) ? base_q - reserve_q : 32'd0;
    end
  end

  assign end_off = (log_sectors_q == '0) ? 32'd0 : div_rem;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_sectors_q  <= 32'd65536;
      sector_bytes_q <= 17'd512;
      block_bytes_q  <= 21'd8192;
      reserve_q      <= 32'd0;
      header_q       <= 13'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOG_SECTORS:  log_sectors_q  <= cfg_data_i;
        CFG_SECTOR_BYTES: sector_bytes_q <= cfg_data_i[16:0];
        CFG_BLOCK_BYTES:  block_bytes_q  <= cfg_data_i[20:0];
        CFG_RESERVE:      reserve_q      <= cfg_data_i;
        CFG_HEADER:       header_q       <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= op_i;
      tag_q    <= item_tag_i;
      ibytes_q <= item_bytes_i;
      ifrees_q <= item_frees_i;
      nhead_q  <= new_head_i;
    end
  end

  // Queue storage: enqueue at the end, compact during the sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      mem_bytes_q[count_q[AW-1:0]] <= ibytes_q;
      mem_frees_q[count_q[AW-1:0]] <= ifrees_q;
      mem_tags_q[count_q[AW-1:0]]  <= tag_q;
    end else if (cmd_i.swp_copy) begin
      mem_bytes_q[wr_q[AW-1:0]] <= rd_bytes;
      mem_frees_q[wr_q[AW-1:0]] <= rd_frees;
      mem_tags_q[wr_q[AW-1:0]]  <= rd_tag;
    end
  end

  // Control state of the queue and the log
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      tail_q     <= '0;
      head_q     <= '0;
      seq_q      <= 64'd1;
      idx_q      <= '0;
      wr_q       <= '0;
      n_q        <= '0;
      k_q        <= '0;
      taken_q    <= '0;
      all_free_q <= 1'b1;
    end else begin
      if (cmd_i.enq) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.set_head) begin
        head_q <= nhead_q;
      end
      if (cmd_i.walk_init) begin
        idx_q      <= '0;
        n_q        <= '0;
        taken_q    <= '0;
        all_free_q <= 1'b1;
      end
      if (cmd_i.take) begin
        taken_q[ridx] <= 1'b1;
        n_q           <= n_q + 1'b1;
        idx_q         <= idx_q + 1'b1;
        all_free_q    <= all_free_q & rd_frees;
      end
      if (cmd_i.skip) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.commit) begin
        tail_q <= end_off;
        seq_q  <= seq_q + (wraps_q ? 64'd2 : 64'd1);
      end
      if (cmd_i.swp_init) begin
        idx_q <= '0;
        wr_q  <= '0;
        k_q   <= '0;
      end
      if (cmd_i.swp_copy) begin
        idx_q <= idx_q + 1'b1;
        wr_q  <= wr_q + 1'b1;
      end
      if (cmd_i.emit && (cmd_i.st == ST_BATCHED)) begin
        idx_q <= idx_q + 1'b1;
        k_q   <= k_q + 1'b1;
      end
      if (cmd_i.swp_done) begin
        count_q <= wr_q;
      end
    end
  end

  // Batch payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      bytes_q <= {9'd0, header_q};
      room_q  <= room;
      base_q  <= free_sec;
    end
    if (cmd_i.take) begin
      bytes_q <= sum[21:0];
    end
    if (cmd_i.place) begin
      nsec_q    <= div_quot[23:0];
      wraps_q   <= (div_quot > {1'b0, room_q});
      off_q     <= (div_quot > {1'b0, room_q}) ? 32'd0 : tail_q;
      wrapoff_q <= (div_quot > {1'b0, room_q}) ? tail_q : 32'd0;
    end
    if (cmd_i.commit) begin
      seqlo_q <= seq_q;
      seqhi_q <= wraps_q ? seq_q + 64'd1 : seq_q;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q     <= cmd_i.st;
      otag_q       <= 8'd0;
      obatch_off_q <= 32'd0;
      oend_q       <= 32'd0;
      owraps_q     <= 1'b0;
      owrapoff_q   <= 32'd0;
      osec_q       <= 12'd0;
      oseqlo_q     <= 64'd0;
      oseqhi_q     <= 64'd0;
      olast_q      <= 1'b1;
      case (cmd_i.st) inside
        ST_QUEUED, ST_QFULL: otag_q <= tag_q;
        ST_LOGFULL: otag_q <= mem_tags_q[0];
        ST_BATCHED: begin
          otag_q       <= rd_tag;
          obatch_off_q <= off_q;
          oend_q       <= tail_q;
          owraps_q     <= wraps_q;
          owrapoff_q   <= wrapoff_q;
          osec_q       <= (nsec_q > 24'd4095) ? 12'd4095 : nsec_q[11:0];
          oseqlo_q     <= seqlo_q;
          oseqhi_q     <= seqhi_q;
          olast_q      <= ((k_q + 1'b1) == n_q);
        end
        default: otag_q <= 8'd0;
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.op        = op_q;
    sts_o.q_full    = (count_q >= IW'(QUEUE_DEPTH));
    sts_o.q_empty   = (count_q == '0);
    sts_o.walk_end  = (idx_q >= count_q) || (n_q >= NW'(MAX_ABSORB));
    sts_o.over_blk  = (n_q != '0) && (sum > {2'b00, block_bytes_q});
    sts_o.fits      = (consume <= {2'b00, avail});
    sts_o.n_zero    = (n_q == '0);
    sts_o.div_done  = div_done;
    sts_o.out_free  = out_free;
    sts_o.swp_end   = (idx_q >= count_q);
    sts_o.swp_taken = taken_q[ridx];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_tag_o       = otag_q;
  assign batch_offset_o  = obatch_off_q;
  assign batch_end_o     = oend_q;
  assign batch_wraps_o   = owraps_q;
  assign wrap_offset_o   = owrapoff_q;
  assign batch_sectors_o = osec_q;
  assign seq_low_o       = oseqlo_q;
  assign seq_high_o      = oseqhi_q;
  assign last_o          = olast_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IW'(QUEUE_DEPTH)) else $error("queue count above depth");
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq |=> count_q == $past(count_q) + 1'b1) else $error("enqueue lost");
  a_batch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.st == ST_BATCHED) |-> n_q != '0)
    else $error("batched result with no absorbed item");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_go |-> !div_busy) else $error("divider restarted while busy");

endmodule

FILE: design/lbsa_ctrl.sv
// ----------------------------------------------------------------------------
// lbsa_ctrl
// Controller: sequences decode, batch walk, placement and the result sweep.
// ----------------------------------------------------------------------------
module lbsa_ctrl
  import lbsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIVI = 4'd3;
  localparam logic [3:0] S_TOT  = 4'd4;
  localparam logic [3:0] S_DIVT = 4'd5;
  localparam logic [3:0] S_MOD  = 4'd6;
  localparam logic [3:0] S_DIVM = 4'd7;
  localparam logic [3:0] S_SWP  = 4'd8;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.op)
          OP_ENQ: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.st   = sts_i.q_full ? ST_QFULL : ST_QUEUED;
              cmd_o.enq  = ~sts_i.q_full;
              state_d    = S_IDLE;
            end
          end
          OP_HEAD: begin
            if (sts_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.st       = ST_HEADSET;
              cmd_o.set_head = 1'b1;
              state_d        = S_IDLE;
            end
          end
          OP_FORM: begin
            if (!sts_i.q_empty) begin
              cmd_o.walk_init = 1'b1;
              state_d         = S_CHK;
            end else if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.st   = ST_QEMPTY;
              state_d    = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CHK: begin
        if (sts_i.walk_end || sts_i.over_blk) begin
          state_d = S_TOT;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DIV_ITEM;
          state_d       = S_DIVI;
        end
      end
      S_DIVI: begin
        if (sts_i.div_done) begin
          if (sts_i.fits) begin
            cmd_o.take = 1'b1;
            state_d    = S_CHK;
          end else if (!sts_i.n_zero) begin
            state_d = S_TOT;
          end else begin
            cmd_o.skip = 1'b1;
            state_d    = S_CHK;
          end
        end
      end
      S_TOT: begin
        if (!sts_i.n_zero) begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DIV_TOTAL;
          state_d       = S_DIVT;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = ST_LOGFULL;
          state_d    = S_IDLE;
        end
      end
      S_DIVT: begin
        if (sts_i.div_done) begin
          cmd_o.place = 1'b1;
          state_d     = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_MOD;
        state_d       = S_DIVM;
      end
      S_DIVM: begin
        if (sts_i.div_done) begin
          cmd_o.commit   = 1'b1;
          cmd_o.swp_init = 1'b1;
          state_d        = S_SWP;
        end
      end
      S_SWP: begin
        if (sts_i.swp_end) begin
          cmd_o.swp_done = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.swp_taken) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.st   = ST_BATCHED;
          end
        end else begin
          cmd_o.swp_copy = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: design/log_batch_space_allocator.sv
// ----------------------------------------------------------------------------
// log_batch_space_allocator
// Group-commit batch allocator for a circular log: pending queue, head and
// tail pointers, batch formation with reserve enforcement and wrap markers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_ready_o   op, item_tag, item_bytes,
//                                                 item_frees, new_head
//  out       output     out_valid_o / out_ready_i status .. last
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  Enqueue and set-head requests are answered from decode, after any output stall.
//  Batch formation runs the shared divider once for each tested queue entry,
//  then twice more to size and place the record, then sweeps every queue
//  entry once to emit the results and compact the queue.
//  A new request is taken only once the previous one is finished; the output
//  register lets the last result wait while the next request is taken.
//  Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module log_batch_space_allocator
  import lbsa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  item_tag_i,
  input  logic [20:0] item_bytes_i,
  input  logic        item_frees_i,
  input  logic [31:0] new_head_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_tag_o,
  output logic [31:0] batch_offset_o,
  output logic [31:0] batch_end_o,
  output logic        batch_wraps_o,
  output logic [31:0] wrap_offset_o,
  output logic [11:0] batch_sectors_o,
  output logic [63:0] seq_low_o,
  output logic [63:0] seq_high_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  lbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbsa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .item_tag_i      (item_tag_i),
    .item_bytes_i    (item_bytes_i),
    .item_frees_i    (item_frees_i),
    .new_head_i      (new_head_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .out_tag_o       (out_tag_o),
    .batch_offset_o  (batch_offset_o),
    .batch_end_o     (batch_end_o),
    .batch_wraps_o   (batch_wraps_o),
    .wrap_offset_o   (wrap_offset_o),
    .batch_sectors_o (batch_sectors_o),
    .seq_low_o       (seq_low_o),
    .seq_high_o      (seq_high_o),
    .last_o          (last_o)
  );

endmodule
